>>> hw/rtl/sha_pkg.sv
// SHA-256 shared types, constants and a rotate helper.
package sha_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 61;
  localparam int unsigned LenPos = 56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_RUN,
    ST_FOLD,
    ST_EMIT
  } ctrl_state_t;

  // command from controller to datapath
  typedef struct packed {
    logic       put_byte;   // shift in message byte, count up
    logic       put_mark;   // shift in 0x80, latch bit length
    logic       put_zero;   // shift in zero pad byte
    logic       put_len;    // shift in next length byte, msb first
    logic       start;      // load working vars and begin rounds
    logic       step;       // one round
    logic       fold;       // add working vars into chain
    logic       reinit;     // back to initial hash, count cleared
  } sha_cmd_t;

  typedef struct packed {
    logic       round_last; // round 63 under way
    logic [5:0] fill;       // bytes in current block
  } sha_stat_t;

  localparam logic [WordW-1:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordW-1:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] v, input int n);
    rotr = (v >> n) | (v << (WordW - n));
  endfunction

endpackage

>>> hw/rtl/sha_datapath.sv
// SHA-256 datapath: byte window, schedule, rounds, chain and count.
module sha_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  sha_pkg::sha_cmd_t       cmd,
  input  logic [7:0]              data_byte,
  input  logic [2:0]              rd_index,
  output sha_pkg::sha_stat_t      stat,
  output logic [31:0]             rd_word
);

  localparam logic [sha_pkg::CountW-1:0] CountInc = 1;

  logic [31:0]                chain [8];
  logic [31:0]                wv [8];
  logic [31:0]                win [16];
  logic [sha_pkg::CountW-1:0] count;
  logic [5:0]                 fill;
  logic [5:0]                 round;
  logic [7:0]                 in_byte;
  logic                       shift_in;
  logic [31:0]                w_new, t1, t2, s0, s1;

  // bit length latched with the 0x80 byte, shifted out a byte at a time
  logic [63:0]                len_sr;

  always_comb begin
    if (cmd.put_mark)      in_byte = 8'h80;
    else if (cmd.put_len)  in_byte = len_sr[63:56];
    else if (cmd.put_zero) in_byte = 8'h00;
    else                   in_byte = data_byte;
  end

  assign shift_in = cmd.put_byte | cmd.put_mark | cmd.put_zero | cmd.put_len;

  assign s0 = sha_pkg::rotr(win[1], 7) ^ sha_pkg::rotr(win[1], 18) ^ (win[1] >> 3);
  assign s1 = sha_pkg::rotr(win[14], 17) ^ sha_pkg::rotr(win[14], 19) ^ (win[14] >> 10);
  assign w_new = s1 + win[9] + s0 + win[0];

  assign t1 = wv[7] + (sha_pkg::rotr(wv[4], 6) ^ sha_pkg::rotr(wv[4], 11)
            ^ sha_pkg::rotr(wv[4], 25)) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6]))
            + sha_pkg::K_TAB[round] + win[0];
  assign t2 = (sha_pkg::rotr(wv[0], 2) ^ sha_pkg::rotr(wv[0], 13)
            ^ sha_pkg::rotr(wv[0], 22)) + ((wv[0] & wv[1]) ^ (wv[0] & wv[2])
            ^ (wv[1] & wv[2]));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      fill  <= '0;
      round <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= sha_pkg::H_INIT[i];
    end else begin
      if (cmd.put_byte) count <= count + CountInc;
      if (shift_in) fill <= fill + 6'd1;
      if (cmd.start) round <= '0;
      else if (cmd.step) round <= round + 6'd1;
      if (cmd.fold)
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + wv[i];
      if (cmd.reinit) begin
        count <= '0;
        fill  <= '0;
        for (int i = 0; i < 8; i++) chain[i] <= sha_pkg::H_INIT[i];
      end
    end
  end

  // bytes shift in at the low end; after 64 of them win[0] holds bytes 0..3
  always_ff @(posedge clk) begin
    if (cmd.put_mark) len_sr <= {count, 3'b000};
    else if (cmd.put_len) len_sr <= {len_sr[55:0], 8'h00};
    if (shift_in) begin
      for (int i = 0; i < 15; i++) win[i] <= {win[i][23:0], win[i+1][31:24]};
      win[15] <= {win[15][23:0], in_byte};
    end else if (cmd.step) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i+1];
      win[15] <= w_new;
    end
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) wv[i] <= chain[i];
    end else if (cmd.step) begin
      wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4]; wv[4] <= wv[3] + t1;
      wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0]; wv[0] <= t1 + t2;
    end
  end

  assign stat.round_last = (round == 6'd63);
  assign stat.fill       = fill;
  assign rd_word         = chain[rd_index];

endmodule

>>> hw/rtl/sha_ctrl.sv
// SHA-256 controller: intake, padding, round sequencing and digest output.
module sha_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic               in_mode,
  input  sha_pkg::sha_stat_t stat,
  input  logic               out_ready,
  output logic               in_ready,
  output logic               out_valid,
  output logic [2:0]         out_index,
  output sha_pkg::sha_cmd_t  cmd
);

  sha_pkg::ctrl_state_t state, state_next;
  logic       finishing, finishing_next;
  logic       spill, spill_next;
  logic [2:0] index, index_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sha_pkg::ST_IDLE;
      finishing <= 1'b0;
      spill     <= 1'b0;
      index     <= '0;
    end else begin
      state     <= state_next;
      finishing <= finishing_next;
      spill     <= spill_next;
      index     <= index_next;
    end
  end

  always_comb begin
    state_next     = state;
    finishing_next = finishing;
    spill_next     = spill;
    index_next     = index;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    case (state)
      sha_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (in_mode) begin
            cmd.put_mark   = 1'b1;
            finishing_next = 1'b1;
            // no room for the length behind the 0x80: a second block follows
            spill_next     = (stat.fill >= 6'(sha_pkg::LenPos));
          end else begin
            cmd.put_byte = 1'b1;
          end
          if (stat.fill == 6'd63) begin
            cmd.start  = 1'b1;
            state_next = sha_pkg::ST_RUN;
          end else if (in_mode) begin
            state_next = sha_pkg::ST_PAD;
          end
        end
      end
      sha_pkg::ST_PAD: begin
        if (!spill && stat.fill >= 6'(sha_pkg::LenPos)) cmd.put_len = 1'b1;
        else cmd.put_zero = 1'b1;
        if (stat.fill == 6'd63) begin
          cmd.start  = 1'b1;
          state_next = sha_pkg::ST_RUN;
        end
      end
      sha_pkg::ST_RUN: begin
        cmd.step = 1'b1;
        if (stat.round_last) state_next = sha_pkg::ST_FOLD;
      end
      sha_pkg::ST_FOLD: begin
        cmd.fold = 1'b1;
        if (!finishing) begin
          state_next = sha_pkg::ST_IDLE;
        end else if (spill) begin
          spill_next = 1'b0;
          state_next = sha_pkg::ST_PAD;
        end else begin
          state_next = sha_pkg::ST_EMIT;
        end
      end
      sha_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          index_next = index + 3'd1;
          if (index == 3'd7) begin
            cmd.reinit     = 1'b1;
            finishing_next = 1'b0;
            state_next     = sha_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = sha_pkg::ST_IDLE;
    endcase
  end

  assign out_index = index;

endmodule

>>> hw/rtl/sha256_message_digest.sv
// SHA-256 message digest top level.
//  channel | dir | tdata                          | tuser/tlast
//  s_axis  | in  | data_byte                      | tuser: mode
//  m_axis  | out | digest_word                    | tuser: word_index, tlast: last_word
// The 64th byte of a block closes intake during the 64 rounds at one per cycle and
// the add into the chain. Finish writes the padding one byte per cycle up to the
// block end and compresses; a second block follows when the 0x80 lands at byte 56
// or later. Then eight words are offered. rst is synchronous and returns the
// hash to its initial value. m_axis stalls hold the word; intake is closed
// until the last word is taken.
module sha256_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast
);

  sha_pkg::sha_cmd_t  cmd;
  sha_pkg::sha_stat_t stat;
  logic [2:0]         index;

  sha_ctrl u_ctrl (
    .clk, .rst,
    .in_fire   (s_axis_tvalid & s_axis_tready),
    .in_mode   (s_axis_tuser),
    .stat,
    .out_ready (m_axis_tready),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_index (index),
    .cmd
  );

  sha_datapath u_dp (
    .clk, .rst, .cmd,
    .data_byte (s_axis_tdata),
    .rd_index  (index),
    .stat,
    .rd_word   (m_axis_tdata)
  );

  assign m_axis_tuser = index;
  assign m_axis_tlast = (index == 3'd7);

endmodule

>>> bench/tb_sha256_message_digest.sv
// Self-checking bench for the SHA-256 message digest block.
`timescale 1ns / 1ps

class digest_scoreboard;
  logic [31:0] chain [8];
  logic [7:0]  blk [64];
  logic [60:0] nbytes;
  logic [31:0] want_word [$];
  logic [2:0]  want_idx [$];
  logic        want_last [$];
  int          errors;
  int          words_seen;
  int          digests;

  function new();
    errors = 0;
    words_seen = 0;
    digests = 0;
    reinit();
  endfunction

  function void reinit();
    chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    nbytes = '0;
  endfunction

  function logic [31:0] ror(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function void compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int r = 0; r < 16; r++)
      w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
    for (int r = 16; r < 64; r++)
      w[r] = (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
           + (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
    v = chain;
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::K_TAB[r] + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int r = 0; r < 8; r++) chain[r] += v[r];
  endfunction

  // one accepted request
  function void note_request(logic mode, logic [7:0] b);
    int fill;
    logic [63:0] bits;
    fill = nbytes[5:0];
    if (!mode) begin
      blk[fill] = b;
      nbytes++;
      if (fill == 63) compress();
      return;
    end
    bits = {nbytes, 3'b000};
    blk[fill] = 8'h80;
    fill++;
    if (fill > 56) begin
      while (fill < 64) blk[fill++] = 8'h00;
      compress();
      fill = 0;
    end
    while (fill < 56) blk[fill++] = 8'h00;
    for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      want_word.push_back(chain[i]);
      want_idx.push_back(3'(i));
      want_last.push_back(i == 7);
    end
    digests++;
    reinit();
  endfunction

  function void check_word(logic [31:0] w, logic [2:0] idx, logic last);
    words_seen++;
    if (want_word.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected digest word %h idx %0d", w, idx);
      return;
    end
    if (w !== want_word[0] || idx !== want_idx[0] || last !== want_last[0]) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp %h/%0d/%b got %h/%0d/%b",
                 want_word[0], want_idx[0], want_last[0], w, idx, last);
    end
    void'(want_word.pop_front());
    void'(want_idx.pop_front());
    void'(want_last.pop_front());
  endfunction
endclass

module tb_sha256_message_digest;
  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  localparam logic MODE_BYTE   = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  digest_scoreboard sb;
  bit quiet_phase;
  bit hold_off;
  int sent;

  sha256_message_digest dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send(logic mode, logic [7:0] b);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(mode, b);
    sent++;
  endtask

  task automatic send_msg(int len);
    for (int i = 0; i < len; i++) send(MODE_BYTE, 8'($urandom));
    send(MODE_FINISH, 8'($urandom));
  endtask

  // receiver
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (hold_off) begin
        // long hold-off, counted here while the sender keeps offering
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        gap = $urandom_range(1, 4);
        repeat (gap - 1) @(posedge clk);
        // words cannot be accepted while ready is low, so nothing to check here
      end else m_axis_tready <= 1'b1;
    end
  end

  initial begin
    int wait_cycles;
    int len;
    sb = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = MODE_BYTE;
    quiet_phase = 0;
    hold_off = 0;
    sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty message, padding boundaries, extreme bytes, finish data
    send(MODE_FINISH, 8'hff);
    send(MODE_BYTE, 8'h00); send(MODE_BYTE, 8'hff); send(MODE_FINISH, 8'h00);
    send_msg(55);
    send_msg(56);
    send_msg(63);
    send_msg(64);

    // long receiver stall while a digest is pending and bytes keep coming
    hold_off = 1;
    send_msg(3);
    for (int i = 0; i < 10; i++) send(MODE_BYTE, 8'($urandom));
    send(MODE_FINISH, 8'h00);

    while (sent < 290) begin
      case ($urandom_range(0, 3))
        0: len = $urandom_range(0, 10);
        1: len = $urandom_range(50, 70);
        2: len = $urandom_range(0, 130);
        default: len = $urandom_range(11, 49);
      endcase
      if (sent + len + 1 > 315) len = 315 - sent - 1;
      send_msg(len);
      if (sent > 250) quiet_phase = 1;
    end
    s_axis_tvalid <= 1'b0;

    wait_cycles = 0;
    while (sb.want_word.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (200) @(posedge clk);
    $display("covered %0d requests, %0d digests, %0d words checked",
             sent, sb.digests, sb.words_seen);
    if (sb.errors == 0 && sb.want_word.size() == 0)
      $display("[ OK ] regression clean");
    else begin
      $display("%0d mismatches, %0d words outstanding", sb.errors, sb.want_word.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

>>> filelist.f
hw/rtl/sha_pkg.sv
hw/rtl/sha_datapath.sv
hw/rtl/sha_ctrl.sv
hw/rtl/sha256_message_digest.sv
bench/tb_sha256_message_digest.sv
